// ----- rtl/imb_pkg.sv -----
// shared types, constants and helpers for the interleaved batched matmul block
package imb_pkg;

	localparam int STORE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int MAX_DIM     = 16;
	localparam int MAX_INNER   = 64;
	localparam int MAX_BATCH   = 4;
	localparam int ELEM_W      = 16;
	localparam int PROD_W      = 2 * ELEM_W;
	localparam int VAL_W       = 38;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 7;

	// operation codes
	localparam logic [1:0] OP_WRITE_LEFT  = 2'd0;
	localparam logic [1:0] OP_WRITE_RIGHT = 2'd1;
	localparam logic [1:0] OP_COMPUTE     = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_LENGTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BATCH_COUNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE_RHS = 3'd4;

	typedef struct packed {
		logic [1:0]               operation;
		logic [11:0]              element_index;
		logic signed [ELEM_W-1:0] element_value;
		logic [3:0]               out_row;
		logic [3:0]               out_col;
		logic [1:0]               out_batch;
	} req_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] product_value;
		logic                    status;
	} rsp_item_t;

	typedef struct packed {
		logic [4:0] row_count;
		logic [4:0] col_count;
		logic [6:0] inner_length;
		logic [2:0] batch_count;
		logic       transpose_rhs;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr_l;
		logic [ADDR_W-1:0] addr_r;
	} rd_ctl_t;

	typedef struct packed {
		logic clear;
		logic mul_en;
		logic acc_en;
	} mac_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_BASE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	function automatic logic [4:0] sat_dim(input logic [4:0] v);
		return (v > 5'(MAX_DIM)) ? 5'(MAX_DIM) : v;
	endfunction

	function automatic logic [6:0] sat_inner(input logic [6:0] v);
		return (v > 7'(MAX_INNER)) ? 7'(MAX_INNER) : v;
	endfunction

	function automatic logic [2:0] sat_batch(input logic [2:0] v);
		return (v > 3'(MAX_BATCH)) ? 3'(MAX_BATCH) : v;
	endfunction

endpackage

// ----- rtl/imb_ram.sv -----
// generic single write port ram with one registered read port
module imb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/imb_mac.sv -----
// shared multiply-accumulate unit: registered product, then running sum
module imb_mac (
	input  logic                              clk,
	input  imb_pkg::mac_ctl_t                 ctl,
	input  logic signed [imb_pkg::ELEM_W-1:0] a,
	input  logic signed [imb_pkg::ELEM_W-1:0] b,
	output logic signed [imb_pkg::VAL_W-1:0]  acc
);
	import imb_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [VAL_W-1:0]  acc_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= a * b;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + {{(VAL_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		end
	end

	assign acc = acc_q;

endmodule

// ----- rtl/imb_ctrl.sv -----
// sequencer: range check, operand address walk, mac control and result register
module imb_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  imb_pkg::cfg_t                    cfg,
	input  logic                             req_valid,
	input  imb_pkg::req_item_t               req_item,
	output logic                             req_stall,
	output imb_pkg::rd_ctl_t                 rd_ctl,
	output imb_pkg::mac_ctl_t                mac_ctl,
	input  logic signed [imb_pkg::VAL_W-1:0] acc,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output imb_pkg::rsp_item_t               rsp_item
);
	import imb_pkg::*;

	state_t state_q, state_d;

	logic [4:0] nr, nc;
	logic [6:0] nk;
	logic [2:0] nb;

	logic [3:0] row_q, col_q;
	logic [1:0] bat_q;
	logic       err_q;
	logic [10:0] rk_q, ck_q;
	logic [6:0]  stride_r_q;
	logic [ADDR_W-1:0] addr_l_q, addr_r_q;
	logic [6:0]  k_q;
	logic        rd_v_q, mul_v_q;
	logic        rsp_valid_q;
	rsp_item_t   rsp_q;

	logic accept, err_d, load_rsp;

	assign nr = sat_dim(cfg.row_count);
	assign nc = sat_dim(cfg.col_count);
	assign nk = sat_inner(cfg.inner_length);
	assign nb = sat_batch(cfg.batch_count);

	assign accept = req_valid && !req_stall;
	assign err_d  = ({1'b0, row_q} >= nr) || ({1'b0, col_q} >= nc) ||
		({1'b0, bat_q} >= nb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		load_rsp  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (accept && req_item.operation == OP_COMPUTE) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_d = err_d ? ST_DONE : ST_BASE;
			end
			ST_BASE: begin
				state_d = (nk == 7'd0) ? ST_DRAIN : ST_RUN;
			end
			ST_RUN: begin
				if (k_q == 7'd1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_v_q && !mul_v_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// result register frees up when the previous item leaves
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// item fields and address setup
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= req_item.out_row;
			col_q <= req_item.out_col;
			bat_q <= req_item.out_batch;
		end
		if (state_q == ST_SETUP) begin
			err_q      <= err_d;
			rk_q       <= {7'd0, row_q} * {4'd0, nk};
			ck_q       <= {7'd0, col_q} * {4'd0, nk};
			stride_r_q <= cfg.transpose_rhs ? {4'd0, nb} : {2'd0, nc} * {4'd0, nb};
		end
		if (state_q == ST_BASE) begin
			addr_l_q <= {1'b0, rk_q} * {9'd0, nb} + {10'd0, bat_q};
			addr_r_q <= cfg.transpose_rhs ? ({1'b0, ck_q} * {9'd0, nb} + {10'd0, bat_q})
				: ({8'd0, col_q} * {9'd0, nb} + {10'd0, bat_q});
			k_q <= nk;
		end else if (state_q == ST_RUN) begin
			addr_l_q <= addr_l_q + {9'd0, nb};
			addr_r_q <= addr_r_q + {5'd0, stride_r_q};
			k_q      <= k_q - 7'd1;
		end
		if (load_rsp) begin
			rsp_q.product_value <= err_q ? '0 : acc;
			rsp_q.status        <= err_q;
		end
	end

	// read data and product valid flags trail the address walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_q      <= 1'b0;
			mul_v_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_v_q  <= (state_q == ST_RUN);
			mul_v_q <= rd_v_q;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rd_ctl.en     = (state_q == ST_RUN);
	assign rd_ctl.addr_l = addr_l_q;
	assign rd_ctl.addr_r = addr_r_q;

	assign mac_ctl.clear  = (state_q == ST_SETUP);
	assign mac_ctl.mul_en = rd_v_q;
	assign mac_ctl.acc_en = mul_v_q;

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

endmodule

// ----- rtl/interleaved_batched_matmul_top.sv -----
// top level of the interleaved batched matrix-multiply engine
// A write item (left or right element) is written into its operand ram and the
// block is ready again in the next cycle. A compute item walks the inner dimension
// through one shared multiply-accumulate unit, one operand pair per cycle read
// from the two operand rams, and its result appears in the same cycle that the
// block is ready again. A compute item whose row, column or batch is out of range
// goes from setup straight to done and returns status 1 and value 0. The result
// sits in an output register, so the next item is taken while it waits; a compute
// that finishes while that result is still held waits for it to leave. Operand
// stores are not cleared by reset; configuration is written over a separate port
// that is always ready.
module interleaved_batched_matmul_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  imb_pkg::req_item_t                   req_item,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output imb_pkg::rsp_item_t                   rsp_item,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [imb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [imb_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import imb_pkg::*;

	cfg_t     cfg_q;
	rd_ctl_t  rd_ctl;
	mac_ctl_t mac_ctl;

	logic                     accept, we_l, we_r;
	logic signed [ELEM_W-1:0] l_rd, r_rd;
	logic signed [VAL_W-1:0]  acc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_count     <= 5'd1;
			cfg_q.col_count     <= 5'd1;
			cfg_q.inner_length  <= 7'd1;
			cfg_q.batch_count   <= 3'd1;
			cfg_q.transpose_rhs <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROW_COUNT:     cfg_q.row_count     <= cfg_data[4:0];
				CFG_COL_COUNT:     cfg_q.col_count     <= cfg_data[4:0];
				CFG_INNER_LENGTH:  cfg_q.inner_length  <= cfg_data[6:0];
				CFG_BATCH_COUNT:   cfg_q.batch_count   <= cfg_data[2:0];
				CFG_TRANSPOSE_RHS: cfg_q.transpose_rhs <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign accept = req_valid && !req_stall;
	assign we_l   = accept && (req_item.operation == OP_WRITE_LEFT);
	assign we_r   = accept && (req_item.operation == OP_WRITE_RIGHT);

	imb_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(STORE_DEPTH)
	) u_left_ram (
		.clk  (clk),
		.we   (we_l),
		.waddr(req_item.element_index[ADDR_W-1:0]),
		.wdata(req_item.element_value),
		.re   (rd_ctl.en),
		.raddr(rd_ctl.addr_l),
		.rdata(l_rd)
	);

	imb_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(STORE_DEPTH)
	) u_right_ram (
		.clk  (clk),
		.we   (we_r),
		.waddr(req_item.element_index[ADDR_W-1:0]),
		.wdata(req_item.element_value),
		.re   (rd_ctl.en),
		.raddr(rd_ctl.addr_r),
		.rdata(r_rd)
	);

	imb_mac u_mac (
		.clk(clk),
		.ctl(mac_ctl),
		.a  (l_rd),
		.b  (r_rd),
		.acc(acc)
	);

	imb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req_valid(req_valid),
		.req_item (req_item),
		.req_stall(req_stall),
		.rd_ctl   (rd_ctl),
		.mac_ctl  (mac_ctl),
		.acc      (acc),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item (rsp_item)
	);

endmodule
